// ===== sv/bphd_pkg.sv =====
`timescale 1ns / 1ps
package bphd_pkg;

  localparam int CFG_W   = 16;
  localparam int STATE_W = 2;
  localparam int PIN_W   = 5;
  localparam int SEL_W   = 3;
  localparam int ADDR_W  = 2;

  localparam logic [STATE_W-1:0] ST_NONE    = 2'd0;
  localparam logic [STATE_W-1:0] ST_PRESSED = 2'd1;
  localparam logic [STATE_W-1:0] ST_HOLD    = 2'd2;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [ADDR_W-1:0] REG_PRESS_TICKS = 2'd0;
  localparam logic [ADDR_W-1:0] REG_HOLD_TICKS  = 2'd1;
  localparam logic [ADDR_W-1:0] REG_REPEAT_STEP = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] press_ticks;
    logic [CFG_W-1:0] hold_ticks;
    logic [CFG_W-1:0] repeat_step;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic level;
    logic clear;
  } lane_ctrl_t;

endpackage

// ===== sv/bphd_lane.sv =====
`timescale 1ns / 1ps
module bphd_lane #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bphd_pkg::cfg_t                   cfg,
  input  bphd_pkg::lane_ctrl_t             ctrl,
  output logic [bphd_pkg::STATE_W-1:0]     status
);

  localparam int CMP_W = (COUNT_WIDTH > bphd_pkg::CFG_W) ? COUNT_WIDTH : bphd_pkg::CFG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0]       cnt;
  logic [COUNT_WIDTH-1:0]       cnt_next;
  logic [COUNT_WIDTH-1:0]       cnt_inc;
  logic [CMP_W-1:0]             cnt_ext;
  logic [CMP_W-1:0]             step_ext;
  logic [bphd_pkg::STATE_W-1:0] status_next;
  logic [bphd_pkg::STATE_W-1:0] status_base;

  always_comb begin
    if (ctrl.level) begin
      cnt_inc     = (cnt == CNT_MAX) ? cnt : cnt + COUNT_WIDTH'(1);
      status_base = status;
    end else begin
      cnt_inc     = '0;
      status_base = bphd_pkg::ST_NONE;
    end
    cnt_ext  = CMP_W'(cnt_inc);
    step_ext = CMP_W'(cfg.repeat_step);
    cnt_next    = cnt_inc;
    status_next = status_base;
    if (cnt_ext == CMP_W'(cfg.press_ticks)) begin
      status_next = bphd_pkg::ST_PRESSED;
    end else if (cnt_ext >= CMP_W'(cfg.hold_ticks)) begin
      cnt_next    = (cnt_ext >= step_ext) ? COUNT_WIDTH'(cnt_ext - step_ext) : '0;
      status_next = bphd_pkg::ST_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      status <= bphd_pkg::ST_NONE;
    end else if (ctrl.tick) begin
      cnt    <= cnt_next;
      status <= status_next;
    end else if (ctrl.clear) begin
      status <= bphd_pkg::ST_NONE;
    end
  end

endmodule

// ===== sv/bphd_merge.sv =====
`timescale 1ns / 1ps
module bphd_merge #(
  parameter int NUM_BUTTONS = 5
) (
  input  logic [bphd_pkg::SEL_W-1:0]   which_button,
  input  logic [bphd_pkg::STATE_W-1:0] lane_status [NUM_BUTTONS],
  output logic [bphd_pkg::STATE_W-1:0] button_state
);

  always_comb begin
    button_state = bphd_pkg::ST_NONE;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (32'(which_button) == i) begin
        button_state = lane_status[i];
      end
    end
  end

endmodule

// ===== sv/button_press_hold_detector_unit.sv =====
`timescale 1ns / 1ps
// a query transaction's result is registered and shows on m_tdata in the cycle after acceptance
// throughput: one transaction per cycle while the output is not stalled, ticks update every button lane in parallel
// a new transaction is taken while the output register drains in the same cycle
// reset: synchronous, clears counters and states and loads default thresholds 5, 200, 100
module button_press_hold_detector_unit #(
  parameter int NUM_BUTTONS = 5,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // pin_levels[4:0], which_button[7:5]
  input  logic [0:0]                     s_tuser,   // op[0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // button_state[1:0], zero fill
  input  logic                           cfg_we,
  input  logic [bphd_pkg::ADDR_W-1:0]    cfg_addr,
  input  logic [bphd_pkg::CFG_W-1:0]     cfg_data
);

  bphd_pkg::cfg_t                 cfg;
  logic                           in_acc;
  logic                           tick_acc;
  logic                           query_acc;
  logic [bphd_pkg::PIN_W-1:0]     pin_levels;
  logic [bphd_pkg::SEL_W-1:0]     which_button;
  logic [bphd_pkg::STATE_W-1:0]   lane_status [NUM_BUTTONS];
  logic [bphd_pkg::STATE_W-1:0]   sel_state;
  logic [bphd_pkg::STATE_W-1:0]   result;

  assign pin_levels   = s_tdata[4:0];
  assign which_button = s_tdata[7:5];
  assign s_tready     = !m_tvalid || m_tready;
  assign in_acc       = s_tvalid && s_tready;
  assign tick_acc     = in_acc && (s_tuser[0] == bphd_pkg::OP_TICK);
  assign query_acc    = in_acc && (s_tuser[0] == bphd_pkg::OP_QUERY);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_ticks <= 16'd5;
      cfg.hold_ticks  <= 16'd200;
      cfg.repeat_step <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_addr)
        bphd_pkg::REG_PRESS_TICKS: cfg.press_ticks <= cfg_data;
        bphd_pkg::REG_HOLD_TICKS:  cfg.hold_ticks  <= cfg_data;
        bphd_pkg::REG_REPEAT_STEP: cfg.repeat_step <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    bphd_pkg::lane_ctrl_t ctrl;
    if (i < bphd_pkg::PIN_W) begin : g_pin
      assign ctrl.level = pin_levels[i];
    end else begin : g_nopin
      assign ctrl.level = 1'b0;
    end
    assign ctrl.tick  = tick_acc;
    assign ctrl.clear = query_acc && (32'(which_button) == i);

    bphd_lane #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .cfg    (cfg),
      .ctrl   (ctrl),
      .status (lane_status[i])
    );
  end

  bphd_merge #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_merge (
    .which_button (which_button),
    .lane_status  (lane_status),
    .button_state (sel_state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (query_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (query_acc) begin
      result <= sel_state;
    end
  end

  assign m_tdata = {6'd0, result};

  a_unknown_button: assert property (@(posedge clk) disable iff (rst)
    query_acc && (32'(which_button) >= NUM_BUTTONS) |=> m_tdata[1:0] == bphd_pkg::ST_NONE)
    else $error("unknown button query returned a state");

  a_state_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("result carries an undefined state code");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(query_acc))
    else $error("result appeared without a query transaction");

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    tick_acc && !pin_levels[0] && (cfg.press_ticks != '0) && (cfg.hold_ticks != '0)
      |=> lane_status[0] == bphd_pkg::ST_NONE)
    else $error("released button kept a state");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int NB = 5;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic                       op;
    logic [bphd_pkg::SEL_W-1:0] sel;
    logic [bphd_pkg::PIN_W-1:0] pins;
  } btn_txn_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [bphd_pkg::ADDR_W-1:0] cfg_addr = '0;
  logic [bphd_pkg::CFG_W-1:0] cfg_data = '0;

  button_press_hold_detector_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // thresholds as last written
  logic [bphd_pkg::CFG_W-1:0] press_thr = 16'd5;
  logic [bphd_pkg::CFG_W-1:0] hold_thr = 16'd200;
  logic [bphd_pkg::CFG_W-1:0] step_amt = 16'd100;

  logic [15:0] press_cnt [NB];
  logic [bphd_pkg::STATE_W-1:0] btn_status [NB];

  btn_txn_t txn_fifo [$];
  logic [bphd_pkg::STATE_W-1:0] queried_states [$];
  btn_txn_t cur_txn;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int mismatches = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // model of all button lanes, applied per accepted transaction
  task automatic advance_buttons(input btn_txn_t t);
    logic [15:0] c;
    if (t.op == bphd_pkg::OP_TICK) begin
      for (int i = 0; i < NB; i++) begin
        c = press_cnt[i];
        if (t.pins[i]) begin
          if (c != CNT_MAX) c = c + 16'd1;
        end else begin
          c = '0;
          btn_status[i] = bphd_pkg::ST_NONE;
        end
        if (c == press_thr) begin
          btn_status[i] = bphd_pkg::ST_PRESSED;
        end else if (c >= hold_thr) begin
          c = (c >= step_amt) ? c - step_amt : 16'd0;
          btn_status[i] = bphd_pkg::ST_HOLD;
        end
        press_cnt[i] = c;
      end
    end else if (t.sel < NB) begin
      queried_states.push_back(btn_status[t.sel]);
      btn_status[t.sel] = bphd_pkg::ST_NONE;
    end else begin
      queried_states.push_back(bphd_pkg::ST_NONE);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        press_cnt[i] = '0;
        btn_status[i] = bphd_pkg::ST_NONE;
      end
    end else begin
      if (s_tvalid && s_tready) advance_buttons(cur_txn);
      if (!s_tvalid || s_tready) begin
        if (txn_fifo.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_txn = txn_fifo.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {cur_txn.sel, cur_txn.pins};
          s_tuser <= cur_txn.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [bphd_pkg::STATE_W-1:0] want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (queried_states.size() == 0) begin
          $display("%0t: unexpected result transaction, actual %0d", $time, m_tdata[1:0]);
          mismatches++;
        end else begin
          want = queried_states.pop_front();
          if (m_tdata[1:0] !== want) begin
            $display("%0t: button_state mismatch, expected %0d, actual %0d",
                     $time, want, m_tdata[1:0]);
            mismatches++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic push_tick(input logic [bphd_pkg::PIN_W-1:0] pins);
    btn_txn_t t;
    t.op = bphd_pkg::OP_TICK;
    t.pins = pins;
    t.sel = bphd_pkg::SEL_W'($urandom);
    txn_fifo.push_back(t);
  endtask

  task automatic push_query(input logic [bphd_pkg::SEL_W-1:0] sel);
    btn_txn_t t;
    t.op = bphd_pkg::OP_QUERY;
    t.pins = bphd_pkg::PIN_W'($urandom);
    t.sel = sel;
    txn_fifo.push_back(t);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (txn_fifo.size() != 0 || s_tvalid || queried_states.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_thresholds(input logic [bphd_pkg::CFG_W-1:0] p,
                                input logic [bphd_pkg::CFG_W-1:0] h,
                                input logic [bphd_pkg::CFG_W-1:0] s);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= bphd_pkg::REG_PRESS_TICKS;
    cfg_data <= p;
    @(posedge clk);
    cfg_addr <= bphd_pkg::REG_HOLD_TICKS;
    cfg_data <= h;
    @(posedge clk);
    cfg_addr <= bphd_pkg::REG_REPEAT_STEP;
    cfg_data <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    press_thr = p;
    hold_thr = h;
    step_amt = s;
  endtask

  // held patterns persist over many ticks so press and hold are reached
  task automatic add_random(input int n);
    logic [bphd_pkg::PIN_W-1:0] held;
    held = bphd_pkg::PIN_W'($urandom);
    repeat (n) begin
      case ($urandom_range(19))
        0: held = bphd_pkg::PIN_W'($urandom);
        1, 2, 3: push_query(bphd_pkg::SEL_W'($urandom_range(NB - 1)));
        4: push_query(bphd_pkg::SEL_W'($urandom_range(7)));
        5: push_tick(bphd_pkg::PIN_W'($urandom));
        6: begin
          held[3'($urandom_range(bphd_pkg::PIN_W - 1))] ^= 1'b1;
          push_tick(held);
        end
        default: push_tick(held);
      endcase
    end
  endtask

  initial begin
    logic [bphd_pkg::CFG_W-1:0] p, h, s;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset thresholds
    for (int i = 0; i < 8; i++) push_query(bphd_pkg::SEL_W'(i));
    repeat (5) push_tick(5'h1F);
    push_tick(5'h1E);
    for (int i = 0; i < NB; i++) push_query(bphd_pkg::SEL_W'(i));
    push_query(3'd1);
    push_tick(5'h00);
    push_tick(5'h15);
    push_query(3'd2);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin p = 16'd0; h = 16'hFFFF; s = 16'hFFFF; end
        1: begin p = 16'd3; h = 16'd10; s = 16'd4; end
        2: begin p = 16'd1; h = 16'd3; s = 16'hFFFF; end
        3: begin p = 16'hFFFF; h = 16'd0; s = 16'd0; end
        default: begin
          p = bphd_pkg::CFG_W'($urandom_range(8));
          h = bphd_pkg::CFG_W'($urandom_range(24));
          s = bphd_pkg::CFG_W'($urandom_range(24));
        end
      endcase
      case (ph % 4)
        0: begin src_idle_pct = 0; snk_stall_pct = 0; end
        1: begin src_idle_pct = 60; snk_stall_pct = 0; end
        2: begin src_idle_pct = 0; snk_stall_pct = 60; end
        default: begin src_idle_pct = 17; snk_stall_pct = 17; end
      endcase
      set_thresholds(p, h, s);
      add_random(60);
      drain();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
